// ===== hdl/ppd_pkg.sv =====
// Shared types and constants for the palette pixel downscaler.
// Depends on nothing; imported by every module of the block.
package ppd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF     = 4;
    localparam int ADDR_W              = 3;
    localparam int DATA_W              = 32;

    // register select values, decoded on address bit 2
    localparam logic REG_SCALE_MODE = 1'b0;
    localparam logic REG_FORMAT_565 = 1'b1;

    localparam logic [1:0] MODE_SMOOTH = 2'd0;
    localparam logic [1:0] MODE_SKIP   = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_PIXEL     = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pixel_word;
        logic        line_last;
    } t_out_word;

    // one classified pixel, passed from front to back
    typedef struct packed {
        logic [23:0] rgb;
        logic        emit;
        logic        blend;
        logic [1:0]  phase;
        logic        eol;
        logic        fmt_565;
    } t_cmd;

endpackage

// ===== hdl/ppd_front.sv =====
// Front end: word acceptance, palette memory, column phase and classification.
// Depends on ppd_pkg.
module ppd_front #(
    parameter int PALETTE_ENTRIES = ppd_pkg::PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = ppd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  ppd_pkg::t_in_word                    i_in_word,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_scale_mode,
    input  logic                                 i_format_565,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     i_queue_count,
    output logic                                 o_cmd_valid,
    output ppd_pkg::t_cmd                        o_cmd
);
    import ppd_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [23:0]   mem [PALETTE_ENTRIES];
    logic [23:0]   r_rd_data;
    logic          r_oob;
    logic [1:0]    r_phase;
    logic          r_cmd_valid;
    t_cmd          r_cmd;
    logic          accept;
    logic          in_range;
    logic [CW:0]   occupancy;

    // a word still in this stage is counted as already queued
    assign occupancy  = {1'b0, i_queue_count} + {{CW{1'b0}}, r_cmd_valid};
    assign o_in_stall = (occupancy >= (CW+1)'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = ({1'b0, i_in_word.index} < 9'(PALETTE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            if (i_in_word.func == FUNC_PAL_WRITE) begin
                mem[i_in_word.index[AW-1:0]] <=
                    {i_in_word.red, i_in_word.green, i_in_word.blue};
            end else begin
                r_rd_data <= mem[i_in_word.index[AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= accept && (i_in_word.func == FUNC_PIXEL);
            if (accept && (i_in_word.func == FUNC_PIXEL)) begin
                r_phase <= i_in_word.end_of_line ? 2'd0 : r_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in_word.func == FUNC_PIXEL)) begin
            r_oob           <= !in_range;
            r_cmd.phase     <= r_phase;
            r_cmd.eol       <= i_in_word.end_of_line;
            r_cmd.fmt_565   <= i_format_565;
            r_cmd.rgb       <= 24'd0;
            unique case (i_scale_mode)
                MODE_SMOOTH: begin
                    r_cmd.emit  <= (r_phase != 2'd0);
                    r_cmd.blend <= 1'b1;
                end
                MODE_SKIP: begin
                    r_cmd.emit  <= (r_phase != 2'd0);
                    r_cmd.blend <= 1'b0;
                end
                default: begin
                    r_cmd.emit  <= 1'b1;
                    r_cmd.blend <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd     = r_cmd;
        o_cmd.rgb = r_oob ? 24'd0 : r_rd_data;
    end
    assign o_cmd_valid = r_cmd_valid;

endmodule

// ===== hdl/ppd_queue.sv =====
// Short command queue between front and back ends.
// Depends on ppd_pkg.
module ppd_queue #(
    parameter int QUEUE_DEPTH = ppd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  ppd_pkg::t_cmd                     i_push_cmd,
    input  logic                              i_pop,
    output logic                              o_head_valid,
    output ppd_pkg::t_cmd                     o_head_cmd,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_count
);
    import ppd_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    // push never overflows: the front holds off while the queue is full
    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(do_pop);
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_slot[r_rd_ptr];
    assign o_count      = r_count;

endmodule

// ===== hdl/ppd_back.sv =====
// Back end: held colour, 4-to-3 blend, 565/555 packing and output register.
// Depends on ppd_pkg.
module ppd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  ppd_pkg::t_cmd      i_head_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    output ppd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);
    import ppd_pkg::*;

    logic [23:0] r_held;
    logic        r_out_valid;
    t_out_word   r_out_word;
    logic [7:0]  res_r;
    logic [7:0]  res_g;
    logic [7:0]  res_b;
    logic [15:0] packed_word;

    // weights 3:1, 1:1, 1:3 for phases 1, 2, 3
    function automatic logic [7:0] blend_chan(input logic [7:0] p, input logic [7:0] c,
                                              input logic [1:0] ph);
        logic [9:0] sum;
        begin
            case (ph)
                2'd1:    sum = ({2'b0, p} << 1) + {2'b0, p} + {2'b0, c};
                2'd3:    sum = ({2'b0, c} << 1) + {2'b0, c} + {2'b0, p};
                default: sum = ({2'b0, p} + {2'b0, c}) << 1;
            endcase
            blend_chan = sum[9:2];
        end
    endfunction

    always_comb begin
        if (i_head_cmd.blend) begin
            res_r = blend_chan(r_held[23:16], i_head_cmd.rgb[23:16], i_head_cmd.phase);
            res_g = blend_chan(r_held[15:8],  i_head_cmd.rgb[15:8],  i_head_cmd.phase);
            res_b = blend_chan(r_held[7:0],   i_head_cmd.rgb[7:0],   i_head_cmd.phase);
        end else begin
            res_r = i_head_cmd.rgb[23:16];
            res_g = i_head_cmd.rgb[15:8];
            res_b = i_head_cmd.rgb[7:0];
        end
        if (i_head_cmd.fmt_565) begin
            packed_word = {res_r[7:3], res_g[7:2], res_b[7:3]};
        end else begin
            packed_word = {1'b0, res_r[7:3], res_g[7:3], res_b[7:3]};
        end
    end

    // a silent pixel only updates the held colour, so it never waits
    assign o_pop = i_head_valid &&
                   (!i_head_cmd.emit || !r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 24'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_held <= i_head_cmd.rgb;
            end
            if (o_pop && i_head_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head_cmd.emit) begin
            r_out_word.pixel_word <= packed_word;
            r_out_word.line_last  <= i_head_cmd.eol;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hdl/palette_pixel_downscaler.sv =====
// Top level of the palette pixel downscaler: config registers and the
// front / queue / back pipeline. Depends on ppd_pkg, ppd_front, ppd_queue, ppd_back.
//
// Usage
//  - Input channel (i_in_valid / i_in_word / o_in_stall): a word is either a
//    palette write (func 0: index, red, green, blue) or a source pixel
//    (func 1: colour index, end_of_line flag).
//  - Output channel (o_out_valid / o_out_word / i_out_stall): packed 16-bit
//    pixels in RGB565 or RGB555, line_last on the pixel from an end-of-line
//    source pixel. Smooth mode gives three outputs per four pixels, skip mode
//    drops phase 0, direct mode passes every pixel.
//  - APB port: scale_mode at 0x0, format_565 at 0x4; pready tied high.
//    Write registers only while the pipeline is empty.
//  - Throughput: one word per clock while o_in_stall is low, set by the single-port
//    palette memory read at acceptance and a one-word-per-cycle back end.
//  - Path with an empty queue: o_out_valid rises after the palette read at
//    acceptance, the queue slot and the output register.
//  - Receiver stall: the output register holds its word, the 4-entry queue
//    fills, then o_in_stall rises; nothing is dropped.
//  - Reset (i_rst_n low, synchronous): phase, held colour, queue and output
//    valid clear; scale_mode 0, format_565 1. Palette contents are not
//    cleared and must be written before use.
module palette_pixel_downscaler #(
    parameter int PALETTE_ENTRIES = ppd_pkg::PALETTE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH     = ppd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  ppd_pkg::t_in_word             i_in_word,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output ppd_pkg::t_out_word            o_out_word,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppd_pkg::ADDR_W-1:0]    paddr,
    input  logic [ppd_pkg::DATA_W-1:0]    pwdata,
    output logic [ppd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import ppd_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [1:0]    r_scale_mode;
    logic          r_format_565;
    logic          cfg_write;
    logic          cmd_valid;
    t_cmd          cmd;
    logic          head_valid;
    t_cmd          head_cmd;
    logic          pop;
    logic [CW-1:0] queue_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // registers decoded on address bit 2 only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mode <= MODE_SMOOTH;
            r_format_565 <= 1'b1;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_SCALE_MODE: r_scale_mode <= pwdata[1:0];
                REG_FORMAT_565: r_format_565 <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCALE_MODE: prdata = {{(DATA_W-2){1'b0}}, r_scale_mode};
            REG_FORMAT_565: prdata = {{(DATA_W-1){1'b0}}, r_format_565};
            default:        prdata = '0;
        endcase
    end

    ppd_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .QUEUE_DEPTH     (QUEUE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_word     (i_in_word),
        .o_in_stall    (o_in_stall),
        .i_scale_mode  (r_scale_mode),
        .i_format_565  (r_format_565),
        .i_queue_count (queue_count),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    ppd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (cmd_valid),
        .i_push_cmd   (cmd),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd),
        .o_count      (queue_count)
    );

    ppd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cmd   (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_word   (o_out_word),
        .i_out_stall  (i_out_stall)
    );

endmodule
